@@ hw/rtl/lruc_pkg.sv @@
package lruc_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int KEY_BITS = 32;
	localparam int HANDLE_BITS = 16;
	localparam int LEN_BITS = 24;

	localparam logic [1:0] FUNC_GET = 2'd0;
	localparam logic [1:0] FUNC_PUT = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;
	localparam logic [1:0] FUNC_NOP = 2'd3;

	localparam logic [1:0] KIND_HIT = 2'd0;
	localparam logic [1:0] KIND_MISS = 2'd1;
	localparam logic [1:0] KIND_EVICT = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	localparam logic REG_ENTRY_LIMIT = 1'b0;
	localparam logic REG_BYTE_LIMIT = 1'b1;

	// cell load select
	localparam logic [1:0] SEL_HOLD = 2'd0;
	localparam logic [1:0] SEL_LEFT = 2'd1;
	localparam logic [1:0] SEL_RIGHT = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [HANDLE_BITS-1:0] handle;
		logic [LEN_BITS-1:0] len;
	} entry_t;

	typedef struct packed {
		logic [1:0] func;
		logic [31:0] lookup_key;
		logic [15:0] payload_handle;
		logic [23:0] payload_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] handle_out;
		logic [31:0] evicted_key;
		logic last;
		logic [4:0] entry_count;
		logic [31:0] bytes_held;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} out_item_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [LEN_BITS-1:0] b);
		logic [32:0] s;
		s = {1'b0, a} + 33'(b);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] floor_sub(input logic [31:0] a, input logic [LEN_BITS-1:0] b);
		return (a >= 32'(b)) ? a - 32'(b) : 32'd0;
	endfunction

endpackage

@@ hw/rtl/lruc_cell.sv @@
module lruc_cell (
	input  logic clk,
	input  logic [1:0] sel,
	input  lruc_pkg::entry_t left,
	input  lruc_pkg::entry_t right,
	input  logic [lruc_pkg::KEY_BITS-1:0] key_cmp,
	output lruc_pkg::entry_t q,
	output logic hit
);
	import lruc_pkg::*;

	entry_t ent_q;

	always_ff @(posedge clk) begin
		case (sel)
			SEL_LEFT: ent_q <= left;
			SEL_RIGHT: ent_q <= right;
			default: ent_q <= ent_q;
		endcase
	end

	assign q = ent_q;
	assign hit = (ent_q.key == key_cmp);

endmodule

@@ hw/rtl/lru_cache_with_byte_budget.sv @@
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall   | in_item  (func, key, handle, length)
// out     | out | out_valid/out_stall | out_item (kind, handle, key, last, stats)
// cfg     | in  | cfg_we              | cfg_index, cfg_data
// Get: accept, lookup, output. Clear, no-op and a Put of zero length: accept,
// output. Other Puts: accept, lookup, insert, trim (one entry evicted per
// trim step), then eviction results one at a time if any entry went, else
// output; the recency chain shifts by one position in lookup and insert.
// One item at a time; in_stall is high whenever the sequencer is busy.
// out_stall holds the output register and pauses eviction reporting.
// Reset empties the table, clears counters, limits go to 16 and 64 MiB.
module lru_cache_with_byte_budget #(
	parameter int SLOT_COUNT = lruc_pkg::SLOT_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  lruc_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output lruc_pkg::out_item_t out_item,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [31:0] cfg_data
);
	import lruc_pkg::*;

	localparam int IW = $clog2(SLOT_COUNT + 1);
	localparam int LW = (IW > 5) ? IW : 5;
	localparam int NC = SLOT_COUNT + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_INS = 3'd2;
	localparam logic [2:0] ST_TRIM = 3'd3;
	localparam logic [2:0] ST_EVICT = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [2:0] st_q;
	logic [1:0] op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic [LEN_BITS-1:0] len_q;
	logic [IW-1:0] count_q;
	logic [IW-1:0] ehi_q;
	logic [IW-1:0] e_q;
	logic any_ev_q;
	logic [31:0] bytes_q;
	logic [31:0] hits_q;
	logic [31:0] miss_q;
	logic [4:0] ent_lim_q;
	logic [31:0] byte_lim_q;
	logic [1:0] kind_q;
	logic [HANDLE_BITS-1:0] rhdl_q;
	logic out_valid_q;
	out_item_t out_q;

	entry_t cells [NC];
	entry_t lefts [NC];
	entry_t rights [NC];
	logic [1:0] sels [NC];
	logic [NC-1:0] match;
	logic [NC-1:0] vmatch;
	logic hit_any;
	logic [IW-1:0] hit_idx;
	entry_t head;
	logic out_free;
	logic out_load;
	logic accept;
	logic [LW-1:0] elim;
	logic trim;
	logic forced;
	logic [IW-1:0] cnt_m1;
	logic last_ev;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		assign lefts[i] = (i == 0) ? head : cells[(i == 0) ? 0 : i - 1];
		assign rights[i] = (i == NC - 1) ? cells[i] : cells[(i == NC - 1) ? i : i + 1];
		lruc_cell u_cell (
			.clk(clk),
			.sel(sels[i]),
			.left(lefts[i]),
			.right(rights[i]),
			.key_cmp(key_q),
			.q(cells[i]),
			.hit(match[i])
		);
		assign vmatch[i] = match[i] && (IW'(i) < count_q) && (i < SLOT_COUNT);
	end

	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = NC - 1; i >= 0; i--) begin
			if (vmatch[i]) begin
				hit_any = 1'b1;
				hit_idx = IW'(i);
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free && (st_q == ST_EVICT || st_q == ST_OUT);
	assign in_stall = (st_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign elim = (ent_lim_q == 5'd0) ? LW'(1) :
		((LW'(ent_lim_q) > LW'(SLOT_COUNT)) ? LW'(SLOT_COUNT) : LW'(ent_lim_q));
	assign trim = (count_q != '0) && ((LW'(count_q) > elim) || (bytes_q > byte_lim_q));
	assign forced = (count_q == IW'(SLOT_COUNT));
	assign cnt_m1 = count_q - IW'(1);
	assign last_ev = (e_q == count_q);

	always_comb begin
		head = cells[hit_idx];
		if (st_q == ST_INS) begin
			head.key = key_q;
			head.handle = hdl_q;
			head.len = len_q;
		end
		for (int i = 0; i < NC; i++) begin
			sels[i] = SEL_HOLD;
			if (st_q == ST_LOOK && hit_any) begin
				if (op_q == FUNC_GET && IW'(i) <= hit_idx) sels[i] = SEL_LEFT;
				if (op_q == FUNC_PUT && IW'(i) >= hit_idx) sels[i] = SEL_RIGHT;
			end
			if (st_q == ST_INS) sels[i] = SEL_LEFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			count_q <= '0;
			bytes_q <= '0;
			hits_q <= '0;
			miss_q <= '0;
			ent_lim_q <= 5'd16;
			byte_lim_q <= 32'd67108864;
			out_valid_q <= 1'b0;
			any_ev_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ENTRY_LIMIT: ent_lim_q <= cfg_data[4:0];
					REG_BYTE_LIMIT: byte_lim_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= in_item.func;
						key_q <= in_item.lookup_key[KEY_BITS-1:0];
						hdl_q <= in_item.payload_handle[HANDLE_BITS-1:0];
						len_q <= in_item.payload_length;
						kind_q <= KIND_DONE;
						rhdl_q <= '0;
						any_ev_q <= 1'b0;
						if (in_item.func == FUNC_GET ||
							(in_item.func == FUNC_PUT && in_item.payload_length != '0)) begin
							st_q <= ST_LOOK;
						end else begin
							if (in_item.func == FUNC_CLEAR) begin
								count_q <= '0;
								bytes_q <= '0;
							end
							st_q <= ST_OUT;
						end
					end
				end
				ST_LOOK: begin
					if (op_q == FUNC_GET) begin
						if (hit_any) begin
							if (hits_q != 32'hFFFF_FFFF) hits_q <= hits_q + 32'd1;
							kind_q <= KIND_HIT;
							rhdl_q <= cells[hit_idx].handle;
						end else begin
							if (miss_q != 32'hFFFF_FFFF) miss_q <= miss_q + 32'd1;
							kind_q <= KIND_MISS;
						end
						st_q <= ST_OUT;
					end else begin
						if (hit_any) begin
							bytes_q <= floor_sub(bytes_q, cells[hit_idx].len);
							count_q <= cnt_m1;
						end
						st_q <= ST_INS;
					end
				end
				ST_INS: begin
					bytes_q <= sat_add(forced ?
						floor_sub(bytes_q, cells[SLOT_COUNT-1].len) : bytes_q, len_q);
					count_q <= forced ? count_q : count_q + IW'(1);
					ehi_q <= forced ? IW'(SLOT_COUNT) : count_q;
					any_ev_q <= forced;
					st_q <= ST_TRIM;
				end
				ST_TRIM: begin
					if (trim) begin
						bytes_q <= floor_sub(bytes_q, cells[cnt_m1].len);
						count_q <= cnt_m1;
						any_ev_q <= 1'b1;
					end else begin
						e_q <= ehi_q;
						st_q <= any_ev_q ? ST_EVICT : ST_OUT;
					end
				end
				ST_EVICT: begin
					if (out_free) begin
						out_q <= '{kind: KIND_EVICT, handle_out: 16'(cells[e_q].handle),
							evicted_key: 32'(cells[e_q].key), last: last_ev,
							entry_count: 5'(count_q), bytes_held: bytes_q,
							hit_total: hits_q, miss_total: miss_q};
						if (last_ev) st_q <= ST_IDLE;
						else e_q <= e_q - IW'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_q <= '{kind: kind_q, handle_out: 16'(rhdl_q), evicted_key: 32'd0,
							last: 1'b1, entry_count: 5'(count_q), bytes_held: bytes_q,
							hit_total: hits_q, miss_total: miss_q};
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IW'(SLOT_COUNT))
		else $error("entry count above table size");

	a_evict_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EVICT |-> e_q >= count_q)
		else $error("eviction index below live entries");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_item.func == FUNC_CLEAR |=> count_q == '0 && bytes_q == '0)
		else $error("clear left entries behind");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EVICT || st_q == ST_TRIM |-> in_stall)
		else $error("input taken during eviction");

endmodule

@@ tb/sv/tb.sv @@
module tb;
	import lruc_pkg::*;

	localparam int SLOTS = 16;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	always #6 clk = ~clk;

	lru_cache_with_byte_budget uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// cache shadow
	logic [4:0] lim_entries;
	logic [31:0] lim_bytes;
	logic sh_valid [SLOTS];
	logic [31:0] sh_key [SLOTS];
	logic [15:0] sh_handle [SLOTS];
	logic [23:0] sh_len [SLOTS];
	int sh_rank [SLOTS];
	logic [31:0] sh_bytes, sh_hits, sh_misses;

	out_item_t pending_results[$];
	out_item_t step_buf[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_off = 1'b0;
	int quiet_cycles = 0;

	function automatic int count_held();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++) if (sh_valid[i]) n++;
		return n;
	endfunction

	function automatic int lookup(logic [31:0] k);
		for (int i = 0; i < SLOTS; i++) if (sh_valid[i] && sh_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void remove_slot(int s);
		for (int i = 0; i < SLOTS; i++)
			if (i != s && sh_valid[i] && sh_rank[i] > sh_rank[s]) sh_rank[i]--;
		sh_valid[s] = 1'b0;
		sh_rank[s] = 0;
		sh_bytes = (sh_bytes >= 32'(sh_len[s])) ? sh_bytes - 32'(sh_len[s]) : 32'd0;
	endfunction

	function automatic void push_result(logic [1:0] k, logic [15:0] h, logic [31:0] ky);
		out_item_t r;
		r = '0;
		r.kind = k;
		r.handle_out = h;
		r.evicted_key = ky;
		step_buf.push_back(r);
	endfunction

	function automatic void evict_lru();
		int b;
		b = -1;
		for (int i = 0; i < SLOTS; i++)
			if (sh_valid[i] && (b < 0 || sh_rank[i] > sh_rank[b])) b = i;
		if (b < 0) return;
		push_result(KIND_EVICT, sh_handle[b], sh_key[b]);
		remove_slot(b);
	endfunction

	function automatic void predict_access(in_item_t it);
		int s, lim, c;
		logic [32:0] sum;
		step_buf.delete();
		if (it.func == FUNC_GET) begin
			s = lookup(it.lookup_key);
			if (s >= 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (i != s && sh_valid[i] && sh_rank[i] < sh_rank[s]) sh_rank[i]++;
				sh_rank[s] = 0;
				if (sh_hits != '1) sh_hits++;
				push_result(KIND_HIT, sh_handle[s], '0);
			end else begin
				if (sh_misses != '1) sh_misses++;
				push_result(KIND_MISS, '0, '0);
			end
		end else if (it.func == FUNC_PUT && it.payload_length != 0) begin
			lim = (lim_entries == 0) ? 1 : (lim_entries > SLOTS ? SLOTS : lim_entries);
			s = lookup(it.lookup_key);
			if (s >= 0) remove_slot(s);
			if (count_held() >= SLOTS) evict_lru();
			s = -1;
			for (int i = SLOTS - 1; i >= 0; i--) if (!sh_valid[i]) s = i;
			if (s >= 0) begin
				for (int i = 0; i < SLOTS; i++) if (sh_valid[i]) sh_rank[i]++;
				sh_valid[s] = 1'b1;
				sh_key[s] = it.lookup_key;
				sh_handle[s] = it.payload_handle;
				sh_len[s] = it.payload_length;
				sh_rank[s] = 0;
				sum = {1'b0, sh_bytes} + 33'(it.payload_length);
				sh_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			end
			while (step_buf.size() < SLOTS + 1) begin
				c = count_held();
				if (c == 0 || (c <= lim && sh_bytes <= lim_bytes)) break;
				evict_lru();
			end
			if (step_buf.size() == 0) push_result(KIND_DONE, '0, '0);
		end else if (it.func == FUNC_CLEAR) begin
			for (int i = 0; i < SLOTS; i++) begin
				sh_valid[i] = 1'b0;
				sh_rank[i] = 0;
			end
			sh_bytes = '0;
			push_result(KIND_DONE, '0, '0);
		end else begin
			push_result(KIND_DONE, '0, '0);
		end
		c = count_held();
		foreach (step_buf[k]) begin
			step_buf[k].last = (k == step_buf.size() - 1);
			step_buf[k].entry_count = 5'(c);
			step_buf[k].bytes_held = sh_bytes;
			step_buf[k].hit_total = sh_hits;
			step_buf[k].miss_total = sh_misses;
			pending_results.push_back(step_buf[k]);
		end
	endfunction

	task automatic send_item(logic [1:0] f, logic [31:0] k, logic [15:0] h, logic [23:0] l);
		in_item_t it;
		it = '{func: f, lookup_key: k, payload_handle: h, payload_length: l};
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_access(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ENTRY_LIMIT) lim_entries = v[4:0];
		else lim_bytes = v;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_key();
		return ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(23));
	endfunction

	task automatic send_random(int n);
		logic [1:0] f;
		logic [23:0] l;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0: f = FUNC_CLEAR;
				1: f = FUNC_NOP;
				2, 3, 4, 5, 6, 7, 8, 9: f = FUNC_GET;
				default: f = FUNC_PUT;
			endcase
			case ($urandom_range(4))
				0: l = 24'($urandom());
				1: l = 24'd0;
				default: l = 24'($urandom_range(1, 300));
			endcase
			send_item(f, pick_key(), 16'($urandom()), l);
		end
	endtask

	task automatic test_directed();
		send_item(FUNC_GET, 32'd0, 16'd0, 24'd0);
		send_item(FUNC_PUT, 32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
		send_item(FUNC_GET, 32'hFFFF_FFFF, 16'h0, 24'h0);
		send_item(FUNC_PUT, 32'd0, 16'h0001, 24'd0);
		send_item(FUNC_PUT, 32'd0, 16'h0002, 24'd10);
		send_item(FUNC_PUT, 32'd0, 16'h0003, 24'd20);
		send_item(FUNC_GET, 32'd0, 16'hFFFF, 24'hFF_FFFF);
		send_item(FUNC_NOP, 32'h1234_5678, 16'hABCD, 24'h12_3456);
		for (int i = 1; i <= 17; i++) send_item(FUNC_PUT, 32'(100 + i), 16'(i), 24'd1);
		send_item(FUNC_CLEAR, 32'd0, 16'd0, 24'd0);
		drain();
		write_reg(REG_BYTE_LIMIT, 32'd0);
		send_item(FUNC_PUT, 32'd5, 16'h5, 24'd1);
		drain();
		write_reg(REG_BYTE_LIMIT, 32'hFFFF_FFFF);
		for (int i = 0; i < 16; i++) send_item(FUNC_PUT, 32'(i), 16'(i), 24'hFF_FFFF);
		for (int i = 0; i < 4; i++) send_item(FUNC_PUT, 32'(i % 16), 16'(i), 24'hFF_FFFF);
		drain();
		write_reg(REG_ENTRY_LIMIT, 32'd3);
		send_item(FUNC_PUT, 32'd50, 16'h50, 24'd7);
		drain();
	endtask

	task automatic test_limits_sweep();
		write_reg(REG_ENTRY_LIMIT, 32'd0);
		write_reg(REG_BYTE_LIMIT, 32'd1000);
		send_random(8);
		drain();
		write_reg(REG_ENTRY_LIMIT, 32'd31);
		write_reg(REG_BYTE_LIMIT, 32'd600);
		send_random(8);
		drain();
		write_reg(REG_ENTRY_LIMIT, 32'd16);
		write_reg(REG_BYTE_LIMIT, 32'($urandom()));
		send_random(6);
		drain();
		write_reg(REG_ENTRY_LIMIT, 32'd4);
		write_reg(REG_BYTE_LIMIT, 32'd400);
	endtask

	task automatic test_idle_phases();
		send_idle_pct = 0; stall_pct = 0; send_random(6);
		send_idle_pct = 64; stall_pct = 0; send_random(6);
		send_idle_pct = 0; stall_pct = 64; send_random(6);
		send_idle_pct = 15; stall_pct = 15; send_random(6);
		drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0; stall_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++) send_item(FUNC_PUT, 32'(i), 16'(i), 24'd150);
		join
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", out_item);
			end else begin
				want = pending_results.pop_front();
				if (out_item !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, out_item);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("lru_cache_with_byte_budget regression: fail");
			$finish;
		end
	end

	initial begin
		lim_entries = 5'd16;
		lim_bytes = 32'd67108864;
		for (int i = 0; i < SLOTS; i++) begin
			sh_valid[i] = 1'b0;
			sh_rank[i] = 0;
		end
		sh_bytes = '0; sh_hits = '0; sh_misses = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_limits_sweep();
		test_idle_phases();
		test_backpressure();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("lru_cache_with_byte_budget regression: pass");
		else
			$display("lru_cache_with_byte_budget regression: fail");
		$finish;
	end
endmodule
